// ----- hdl/vsp_pkg.sv -----
`default_nettype none

package vsp_pkg;

   // default field geometry
   localparam int COORD_WIDTH_DEF = 24;
   localparam int TIME_WIDTH_DEF  = 32;
   localparam int FRAC_BITS_DEF   = 8;

   // width of every result value
   localparam int VAL_WIDTH = 32;

   // number of divider lanes: three axes and the speed
   localparam int NUM_LANES = 4;
   localparam int LANE_SPEED = 3;

   // control that travels with a word into the merge stage
   typedef struct packed {
      logic valid;
      logic zero;
   } vsp_ctl_type;

endpackage

`default_nettype wire

// ----- hdl/vsp_if.sv -----
`default_nettype none

// request channel: two timestamped positions
interface vsp_req_if #(
   parameter int COORD_WIDTH = vsp_pkg::COORD_WIDTH_DEF,
   parameter int TIME_WIDTH  = vsp_pkg::TIME_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] cur_x;
   logic signed [COORD_WIDTH-1:0] cur_y;
   logic signed [COORD_WIDTH-1:0] cur_z;
   logic        [TIME_WIDTH-1:0]  cur_time;
   logic signed [COORD_WIDTH-1:0] prev_x;
   logic signed [COORD_WIDTH-1:0] prev_y;
   logic signed [COORD_WIDTH-1:0] prev_z;
   logic        [TIME_WIDTH-1:0]  prev_time;

   modport source (
      output valid, cur_x, cur_y, cur_z, cur_time, prev_x, prev_y, prev_z, prev_time,
      input  ready
   );
   modport sink (
      input  valid, cur_x, cur_y, cur_z, cur_time, prev_x, prev_y, prev_z, prev_time,
      output ready
   );
endinterface

// response channel: velocity, speed and flags
interface vsp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [vsp_pkg::VAL_WIDTH-1:0] vel_x;
   logic signed [vsp_pkg::VAL_WIDTH-1:0] vel_y;
   logic signed [vsp_pkg::VAL_WIDTH-1:0] vel_z;
   logic signed [vsp_pkg::VAL_WIDTH-1:0] speed;
   logic                               zero_interval;
   logic                               saturated;

   modport source (
      output valid, vel_x, vel_y, vel_z, speed, zero_interval, saturated,
      input  ready
   );
   modport sink (
      input  valid, vel_x, vel_y, vel_z, speed, zero_interval, saturated,
      output ready
   );
endinterface

`default_nettype wire

// ----- hdl/vsp_isqrt.sv -----
`default_nettype none

module vsp_isqrt #(
   parameter int COORD_WIDTH = vsp_pkg::COORD_WIDTH_DEF,
   parameter int SIDE_WIDTH  = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    in_valid,
   input  wire logic [COORD_WIDTH:0]    mag_x,
   input  wire logic [COORD_WIDTH:0]    mag_y,
   input  wire logic [COORD_WIDTH:0]    mag_z,
   input  wire logic [SIDE_WIDTH-1:0]   side_in,
   output logic                         out_valid,
   output logic [COORD_WIDTH:0]         root,
   output logic [SIDE_WIDTH-1:0]        side_out
);
   localparam int SW = 2 * COORD_WIDTH + 2;
   localparam int RW = COORD_WIDTH + 1;

   logic [SW-1:0]         sq_x_ff, sq_y_ff, sq_z_ff, sum_ff;
   logic [SIDE_WIDTH-1:0] side_a_ff, side_b_ff;
   logic                  vld_a_ff, vld_b_ff;

   logic [SW-1:0]         rem_ff  [RW];
   logic [RW-1:0]         root_ff [RW];
   logic [SIDE_WIDTH-1:0] side_ff [RW];
   logic                  vld_ff  [RW];

   logic [SW-1:0]         rem_src  [RW];
   logic [RW-1:0]         root_src [RW];
   logic [SIDE_WIDTH-1:0] side_src [RW];
   logic                  vld_src  [RW];

   // squares, then their sum
   always_ff @(posedge clock) begin
      if (en) begin
         sq_x_ff   <= SW'(mag_x) * SW'(mag_x);
         sq_y_ff   <= SW'(mag_y) * SW'(mag_y);
         sq_z_ff   <= SW'(mag_z) * SW'(mag_z);
         side_a_ff <= side_in;
         sum_ff    <= sq_x_ff + sq_y_ff + sq_z_ff;
         side_b_ff <= side_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else if (en) begin
         vld_a_ff <= in_valid;
         vld_b_ff <= vld_a_ff;
      end
   end

   // one root bit per stage, most significant first
   for (genvar s = 0; s < RW; s++) begin : g_stage
      localparam int B = RW - 1 - s;
      logic [SW:0] trial;
      logic        take;

      if (s == 0) begin : g_first
         assign rem_src[s]  = sum_ff;
         assign root_src[s] = '0;
         assign side_src[s] = side_b_ff;
         assign vld_src[s]  = vld_b_ff;
      end else begin : g_next
         assign rem_src[s]  = rem_ff[s-1];
         assign root_src[s] = root_ff[s-1];
         assign side_src[s] = side_ff[s-1];
         assign vld_src[s]  = vld_ff[s-1];
      end

      // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b); low bits of r are still zero
      assign trial = ((SW + 1)'(root_src[s]) << (B + 1)) | ((SW + 1)'(1) << (2 * B));
      assign take  = trial <= {1'b0, rem_src[s]};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= take ? SW'({1'b0, rem_src[s]} - trial) : rem_src[s];
            root_ff[s] <= take ? (root_src[s] | (RW'(1) << B)) : root_src[s];
            side_ff[s] <= side_src[s];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_src[s];
         end
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign root      = root_ff[RW-1];
   assign side_out  = side_ff[RW-1];

endmodule

`default_nettype wire

// ----- hdl/vsp_div_lane.sv -----
`default_nettype none

module vsp_div_lane #(
   parameter int NUM_WIDTH = 33,
   parameter int DEN_WIDTH = vsp_pkg::TIME_WIDTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic [NUM_WIDTH-1:0] num,
   input  wire logic [DEN_WIDTH-1:0] den,
   input  wire logic                 neg_in,
   output logic      [NUM_WIDTH-1:0] quot,
   output logic                      neg_out
);
   logic [DEN_WIDTH-1:0] rem_ff [NUM_WIDTH];
   logic [NUM_WIDTH-1:0] num_ff [NUM_WIDTH];
   logic [NUM_WIDTH-1:0] q_ff   [NUM_WIDTH];
   logic [DEN_WIDTH-1:0] den_ff [NUM_WIDTH];
   logic                 neg_ff [NUM_WIDTH];

   logic [DEN_WIDTH-1:0] rem_src [NUM_WIDTH];
   logic [NUM_WIDTH-1:0] num_src [NUM_WIDTH];
   logic [NUM_WIDTH-1:0] q_src   [NUM_WIDTH];
   logic [DEN_WIDTH-1:0] den_src [NUM_WIDTH];
   logic                 neg_src [NUM_WIDTH];

   // restoring division, one quotient bit per stage
   for (genvar s = 0; s < NUM_WIDTH; s++) begin : g_stage
      logic [DEN_WIDTH:0] shifted;
      logic               ge;

      if (s == 0) begin : g_first
         assign rem_src[s] = '0;
         assign num_src[s] = num;
         assign q_src[s]   = '0;
         assign den_src[s] = den;
         assign neg_src[s] = neg_in;
      end else begin : g_next
         assign rem_src[s] = rem_ff[s-1];
         assign num_src[s] = num_ff[s-1];
         assign q_src[s]   = q_ff[s-1];
         assign den_src[s] = den_ff[s-1];
         assign neg_src[s] = neg_ff[s-1];
      end

      assign shifted = {rem_src[s], num_src[s][NUM_WIDTH-1]};
      assign ge      = shifted >= {1'b0, den_src[s]};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= ge ? DEN_WIDTH'(shifted - {1'b0, den_src[s]})
                            : shifted[DEN_WIDTH-1:0];
            num_ff[s] <= num_src[s] << 1;
            q_ff[s]   <= {q_src[s][NUM_WIDTH-2:0], ge};
            den_ff[s] <= den_src[s];
            neg_ff[s] <= neg_src[s];
         end
      end
   end

   assign quot    = q_ff[NUM_WIDTH-1];
   assign neg_out = neg_ff[NUM_WIDTH-1];

endmodule

`default_nettype wire

// ----- hdl/vsp_merge.sv -----
`default_nettype none

module vsp_merge #(
   parameter int QUOT_WIDTH = 33
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire vsp_pkg::vsp_ctl_type  ctl,
   input  wire logic [QUOT_WIDTH-1:0] quot [vsp_pkg::NUM_LANES],
   input  wire logic                  neg  [vsp_pkg::NUM_LANES],
   vsp_rsp_if.source                  rsp
);
   import vsp_pkg::*;

   localparam int EW = (QUOT_WIDTH > VAL_WIDTH + 1) ? QUOT_WIDTH : VAL_WIDTH + 1;
   localparam logic [EW-1:0] LIM_NEG = EW'(34'h0_8000_0000);
   localparam logic [EW-1:0] LIM_POS = EW'(34'h0_7fff_ffff);

   logic [VAL_WIDTH-1:0] val_in [NUM_LANES];
   logic [VAL_WIDTH-1:0] val_ff [NUM_LANES];
   logic                 sat_in, sat_ff, zero_ff, vld_ff;

   // clip each lane to 32 bits and apply its sign; a zero interval forces all lanes to zero
   always_comb begin
      logic [EW-1:0] mag;
      sat_in = 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
         mag = EW'(quot[i]);
         if (neg[i]) begin
            if (mag > LIM_NEG) begin
               sat_in    = 1'b1;
               val_in[i] = 32'h8000_0000;
            end else begin
               val_in[i] = VAL_WIDTH'(EW'(0) - mag);
            end
         end else begin
            if (mag > LIM_POS) begin
               sat_in    = 1'b1;
               val_in[i] = 32'h7fff_ffff;
            end else begin
               val_in[i] = VAL_WIDTH'(mag);
            end
         end
      end
      if (ctl.zero) begin
         sat_in = 1'b0;
         for (int i = 0; i < NUM_LANES; i++) begin
            val_in[i] = '0;
         end
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (en) begin
         val_ff  <= val_in;
         sat_ff  <= sat_in;
         zero_ff <= ctl.zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= ctl.valid;
      end
   end

   assign rsp.valid         = vld_ff;
   assign rsp.vel_x         = val_ff[0];
   assign rsp.vel_y         = val_ff[1];
   assign rsp.vel_z         = val_ff[2];
   assign rsp.speed         = val_ff[LANE_SPEED];
   assign rsp.zero_interval = zero_ff;
   assign rsp.saturated     = sat_ff;

   // zero interval gives an all-zero word
   a_zero_values: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && zero_ff) |-> (val_ff[0] == '0 && val_ff[1] == '0 && val_ff[2] == '0
                               && val_ff[LANE_SPEED] == '0))
      else $error("zero interval with nonzero result");

   a_zero_no_sat: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && zero_ff) |-> !sat_ff)
      else $error("zero interval flagged as saturated");

   // a clipped word carries at least one limit value
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && sat_ff) |->
         (val_ff[0] == 32'h7fff_ffff || val_ff[0] == 32'h8000_0000 ||
          val_ff[1] == 32'h7fff_ffff || val_ff[1] == 32'h8000_0000 ||
          val_ff[2] == 32'h7fff_ffff || val_ff[2] == 32'h8000_0000 ||
          val_ff[LANE_SPEED] == 32'h7fff_ffff || val_ff[LANE_SPEED] == 32'h8000_0000))
      else $error("saturated flag without a limit value");

endmodule

`default_nettype wire

// ----- hdl/velocity_speed_from_two_positions_core.sv -----
`default_nettype none

// channel    dir  fields
// req_chan   in   cur_x/y/z, cur_time, prev_x/y/z, prev_time
// rsp_chan   out  vel_x/y/z, speed, zero_interval, saturated
//
// one word per cycle while the output is not stalled; pipeline stages:
// input stage, two square/sum stages, COORD_WIDTH+1 root stages, then
// COORD_WIDTH+1+FRAC_BITS divider stages in four parallel lanes, output register
// synchronous active-high reset clears all valid bits
// a stalled output freezes the whole pipeline; req_chan.ready is low only then
module velocity_speed_from_two_positions_core #(
   parameter int COORD_WIDTH = vsp_pkg::COORD_WIDTH_DEF,
   parameter int TIME_WIDTH  = vsp_pkg::TIME_WIDTH_DEF,
   parameter int FRAC_BITS   = vsp_pkg::FRAC_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   vsp_req_if.sink   req_chan,
   vsp_rsp_if.source rsp_chan
);
   import vsp_pkg::*;

   localparam int MW   = COORD_WIDTH + 1;
   localparam int NW   = MW + FRAC_BITS;
   localparam int SIDE = 5 + TIME_WIDTH + 3 * MW;

   logic en;

   logic [TIME_WIDTH-1:0] dt;
   logic [MW-1:0]         d_in   [3];
   logic [MW-1:0]         mag_in [3];

   logic                  vld_ff, zero_ff, dneg_ff;
   logic [TIME_WIDTH-1:0] dmag_ff;
   logic [MW-1:0]         mag_ff  [3];
   logic                  vneg_ff [3];

   logic                  sq_valid;
   logic [MW-1:0]         root;
   logic [SIDE-1:0]       side_in, side_out;

   logic                  s_zero, s_dneg;
   logic [2:0]            s_vneg;
   logic [TIME_WIDTH-1:0] s_dmag;
   logic [MW-1:0]         s_mag [3];

   logic [NW-1:0]         lane_num  [NUM_LANES];
   logic                  lane_neg  [NUM_LANES];
   logic [NW-1:0]         lane_quot [NUM_LANES];
   logic                  lane_nego [NUM_LANES];

   logic                  dv_vld_ff  [NW];
   logic                  dv_zero_ff [NW];
   vsp_ctl_type           mctl;

   // whole pipeline moves when the output word is free or being taken
   assign en             = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = en;

   // deltas and interval
   always_comb begin
      dt        = req_chan.cur_time - req_chan.prev_time;
      d_in[0]   = {req_chan.cur_x[COORD_WIDTH-1], req_chan.cur_x}
                - {req_chan.prev_x[COORD_WIDTH-1], req_chan.prev_x};
      d_in[1]   = {req_chan.cur_y[COORD_WIDTH-1], req_chan.cur_y}
                - {req_chan.prev_y[COORD_WIDTH-1], req_chan.prev_y};
      d_in[2]   = {req_chan.cur_z[COORD_WIDTH-1], req_chan.cur_z}
                - {req_chan.prev_z[COORD_WIDTH-1], req_chan.prev_z};
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = d_in[i][MW-1] ? MW'(0) - d_in[i] : d_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff <= (dt == '0);
         dneg_ff <= dt[TIME_WIDTH-1];
         dmag_ff <= dt[TIME_WIDTH-1] ? TIME_WIDTH'(0) - dt : dt;
         for (int i = 0; i < 3; i++) begin
            mag_ff[i]  <= mag_in[i];
            vneg_ff[i] <= d_in[i][MW-1] ^ dt[TIME_WIDTH-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= req_chan.valid;
      end
   end

   // square root of the squared distance
   assign side_in = {zero_ff, dneg_ff, vneg_ff[2], vneg_ff[1], vneg_ff[0], dmag_ff,
                     mag_ff[2], mag_ff[1], mag_ff[0]};

   vsp_isqrt #(
      .COORD_WIDTH (COORD_WIDTH),
      .SIDE_WIDTH  (SIDE)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld_ff),
      .mag_x     (mag_ff[0]),
      .mag_y     (mag_ff[1]),
      .mag_z     (mag_ff[2]),
      .side_in   (side_in),
      .out_valid (sq_valid),
      .root      (root),
      .side_out  (side_out)
   );

   assign {s_zero, s_dneg, s_vneg, s_dmag, s_mag[2], s_mag[1], s_mag[0]} = side_out;

   // four divider lanes: three axes and the speed
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lane_num[i] = NW'(s_mag[i]) << FRAC_BITS;
         lane_neg[i] = s_vneg[i];
      end
      lane_num[LANE_SPEED] = NW'(root) << FRAC_BITS;
      lane_neg[LANE_SPEED] = s_dneg;
   end

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      vsp_div_lane #(
         .NUM_WIDTH (NW),
         .DEN_WIDTH (TIME_WIDTH)
      ) u_div (
         .clock   (clock),
         .en      (en),
         .num     (lane_num[l]),
         .den     (s_dmag),
         .neg_in  (lane_neg[l]),
         .quot    (lane_quot[l]),
         .neg_out (lane_nego[l])
      );
   end

   // control alongside the divider stages
   always_ff @(posedge clock) begin
      if (en) begin
         dv_zero_ff[0] <= s_zero;
         for (int s = 1; s < NW; s++) begin
            dv_zero_ff[s] <= dv_zero_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NW; s++) begin
            dv_vld_ff[s] <= 1'b0;
         end
      end else if (en) begin
         dv_vld_ff[0] <= sq_valid;
         for (int s = 1; s < NW; s++) begin
            dv_vld_ff[s] <= dv_vld_ff[s-1];
         end
      end
   end

   assign mctl.valid = dv_vld_ff[NW-1];
   assign mctl.zero  = dv_zero_ff[NW-1];

   // clip, flag and register the output word
   vsp_merge #(
      .QUOT_WIDTH (NW)
   ) u_merge (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .ctl   (mctl),
      .quot  (lane_quot),
      .neg   (lane_nego),
      .rsp   (rsp_chan)
   );

endmodule

`default_nettype wire
